/* rtl/ovst_pkg.sv */
// Shared constants and types for the state tracker.
package ovst_pkg;

	localparam int MAX_STATES_DEF  = 16;
	localparam int MAX_SYMBOLS_DEF = 64;
	localparam int SCORE_WIDTH_DEF = 32;

	localparam int CMD_W   = 3;
	localparam int ROW_W   = 4;
	localparam int COL_W   = 6;
	localparam int VALUE_W = 32;
	localparam int SYM_W   = 6;
	localparam int BEST_W  = 4;
	localparam int NST_W   = 5;
	localparam int NSY_W   = 7;

	localparam logic [CMD_W-1:0] CMD_OBSERVE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INIT    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TRANS   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_EMIT    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

	localparam int REG_NUM_STATES  = 0;
	localparam int REG_NUM_SYMBOLS = 1;
	localparam int PADDR_W         = 3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [VALUE_W-1:0] value;
		logic [SYM_W-1:0]   symbol;
	} in_beat_t;

	typedef struct packed {
		logic [BEST_W-1:0]  best_state;
		logic [VALUE_W-1:0] best_score;
	} out_beat_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load_in;     // capture input beat
		logic wr_table;    // perform table write of captured beat
		logic restart;     // clear started flag
		logic clr_acc;     // start a new destination
		logic read_k;      // issue memory reads for pair (k, j)
		logic acc;         // accumulate pair read last cycle
		logic fin_j;       // finish destination j
		logic commit;      // copy next vector, set started
		logic best_step;   // compare one score for best
		logic best_clr;
	} ctl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             sym_ok;
		logic             started;
	} dp_stat_t;

endpackage

/* rtl/ovst_if.sv */
// Valid/ready stream interface carrying one beat of payload.
interface ovst_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/online_viterbi_state_tracker_top.sv */
// Top level of the online Viterbi state tracker.
// Input channel in_ch carries cmd, row, col, value and symbol. Commands 1 to 3
// write the initial, transition and emission tables, command 4 restarts the
// sequence and command 0 observes a symbol. Each in-range observe yields one
// beat on out_ch with the best state and its score; other beats yield none.
// An item is handled one at a time. An observe uses the single shared
// add-compare-select unit, which visits every state pair on later symbols
// (one pair per destination state on the first symbol), and ends with a
// best search over the states in use.
// Reset clears the started flag and the controller; tables are undefined
// until written. num_states and num_symbols reset to 16 and 64.
// While the receiver stalls, the result is held and no new beat is taken.
// The APB port writes register 0 (num_states) at 0x0 and 1 (num_symbols) at 0x4.
module online_viterbi_state_tracker_top #(
	parameter int MAX_STATES  = ovst_pkg::MAX_STATES_DEF,
	parameter int MAX_SYMBOLS = ovst_pkg::MAX_SYMBOLS_DEF,
	parameter int SCORE_WIDTH = ovst_pkg::SCORE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ovst_if.sink        in_ch,
	ovst_if.source      out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [ovst_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;

	logic [ovst_pkg::NST_W-1:0] nst_q;
	logic [ovst_pkg::NSY_W-1:0] nsy_q;
	logic [SW:0] n_eff;
	logic [ovst_pkg::NSY_W-1:0] nsym_eff;
	ovst_pkg::ctl_cmd_t ctl;
	ovst_pkg::dp_stat_t stat;
	logic [SW-1:0] k_idx, j_idx, best_state;
	logic [SCORE_WIDTH-1:0] best_score;
	logic signed [SCORE_WIDTH-1:0] bs;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nst_q <= ovst_pkg::NST_W'(16);
			nsy_q <= ovst_pkg::NSY_W'(64);
		end else if (psel && penable && pwrite) begin
			if (paddr[ovst_pkg::PADDR_W-1:2] == 1'(ovst_pkg::REG_NUM_STATES))
				nst_q <= pwdata[ovst_pkg::NST_W-1:0];
			else if (paddr[ovst_pkg::PADDR_W-1:2] == 1'(ovst_pkg::REG_NUM_SYMBOLS))
				nsy_q <= pwdata[ovst_pkg::NSY_W-1:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[ovst_pkg::PADDR_W-1:2] == 1'(ovst_pkg::REG_NUM_STATES))
			prdata = 32'(nst_q);
		else
			prdata = 32'(nsy_q);
	end

	always_comb begin
		if (nst_q == '0) n_eff = (SW+1)'(1);
		else if (32'(nst_q) > MAX_STATES) n_eff = (SW+1)'(MAX_STATES);
		else n_eff = (SW+1)'(nst_q);
		if (nsy_q == '0) nsym_eff = ovst_pkg::NSY_W'(1);
		else if (32'(nsy_q) > MAX_SYMBOLS) nsym_eff = ovst_pkg::NSY_W'(MAX_SYMBOLS);
		else nsym_eff = nsy_q;
	end

	ovst_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready),
		.stat, .n_eff, .ctl, .k_idx, .j_idx
	);

	ovst_dp #(.MAX_STATES(MAX_STATES), .MAX_SYMBOLS(MAX_SYMBOLS),
		.SCORE_WIDTH(SCORE_WIDTH)) u_dp (
		.clk, .arst_n, .in_beat(in_ch.data), .ctl, .k_idx, .j_idx,
		.nsym_eff, .stat, .best_state, .best_score
	);

	always_comb begin
		bs = best_score;
		out_ch.data.best_state = ovst_pkg::BEST_W'(best_state);
		if (SCORE_WIDTH <= ovst_pkg::VALUE_W)
			out_ch.data.best_score = ovst_pkg::VALUE_W'(bs);
		else if (bs > $signed(SCORE_WIDTH'(32'sh7FFFFFFF)))
			out_ch.data.best_score = 32'h7FFFFFFF;
		else if (bs < -$signed(SCORE_WIDTH'(33'sh80000000)))
			out_ch.data.best_score = 32'h80000000;
		else
			out_ch.data.best_score = ovst_pkg::VALUE_W'(bs);
	end
endmodule

/* rtl/ovst_dp.sv */
// Datapath: tables, score vectors and the shared add-compare-select unit.
module ovst_dp #(
	parameter int MAX_STATES  = ovst_pkg::MAX_STATES_DEF,
	parameter int MAX_SYMBOLS = ovst_pkg::MAX_SYMBOLS_DEF,
	parameter int SCORE_WIDTH = ovst_pkg::SCORE_WIDTH_DEF,
	parameter int SW          = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1,
	parameter int YW          = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ovst_pkg::in_beat_t   in_beat,
	input  ovst_pkg::ctl_cmd_t   ctl,
	input  logic [SW-1:0]        k_idx,
	input  logic [SW-1:0]        j_idx,
	input  logic [ovst_pkg::NSY_W-1:0] nsym_eff,
	output ovst_pkg::dp_stat_t   stat,
	output logic [SW-1:0]        best_state,
	output logic [SCORE_WIDTH-1:0] best_score
);
	localparam logic signed [SCORE_WIDTH-1:0] SMAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
	localparam logic signed [SCORE_WIDTH-1:0] SMIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};

	logic [SCORE_WIDTH-1:0] init_mem  [MAX_STATES];
	logic [SCORE_WIDTH-1:0] trans_mem [MAX_STATES*MAX_STATES];
	logic [SCORE_WIDTH-1:0] emit_mem  [MAX_STATES*MAX_SYMBOLS];
	logic signed [SCORE_WIDTH-1:0] score_q [MAX_STATES];
	logic signed [SCORE_WIDTH-1:0] next_q  [MAX_STATES];

	ovst_pkg::in_beat_t in_q;
	logic started_q;
	logic signed [SCORE_WIDTH-1:0] val_sat;
	logic signed [SCORE_WIDTH-1:0] trans_rd_q, emit_rd_q, init_rd_q, prev_rd_q;
	logic signed [SCORE_WIDTH-1:0] acc_q, cand;
	logic signed [SCORE_WIDTH-1:0] fin_val;
	logic first_q;
	logic signed [SCORE_WIDTH-1:0] best_q;
	logic [SW-1:0] best_idx_q;
	logic row_ok, tcol_ok, ecol_ok;

	function automatic logic signed [SCORE_WIDTH-1:0] log_add(
		input logic signed [SCORE_WIDTH-1:0] a, input logic signed [SCORE_WIDTH-1:0] b);
		logic signed [SCORE_WIDTH:0] s;
		begin
			s = {a[SCORE_WIDTH-1], a} + {b[SCORE_WIDTH-1], b};
			if (a == SMIN || b == SMIN) return SMIN;
			if (s[SCORE_WIDTH] != s[SCORE_WIDTH-1]) return s[SCORE_WIDTH] ? SMIN : SMAX;
			return s[SCORE_WIDTH-1:0];
		end
	endfunction

	always_comb begin
		logic signed [ovst_pkg::VALUE_W-1:0] v;
		v = in_q.value;
		if (SCORE_WIDTH >= ovst_pkg::VALUE_W)
			val_sat = SCORE_WIDTH'(v);
		else if (v > $signed(ovst_pkg::VALUE_W'(SMAX)))
			val_sat = SMAX;
		else if (v < $signed(ovst_pkg::VALUE_W'(SMIN)))
			val_sat = SMIN;
		else
			val_sat = SCORE_WIDTH'(v);
	end

	assign row_ok  = 32'(in_q.row) < MAX_STATES;
	assign tcol_ok = 32'(in_q.col) < MAX_STATES;
	assign ecol_ok = 32'(in_q.col) < MAX_SYMBOLS;

	always_ff @(posedge clk) begin
		if (ctl.load_in) in_q <= in_beat;
		if (ctl.wr_table) begin
			unique case (in_q.cmd)
				ovst_pkg::CMD_INIT: if (row_ok) init_mem[SW'(in_q.row)] <= val_sat;
				ovst_pkg::CMD_TRANS:
					if (row_ok && tcol_ok)
						trans_mem[(2*SW)'({SW'(in_q.row), SW'(in_q.col)})] <= val_sat;
				ovst_pkg::CMD_EMIT:
					if (row_ok && ecol_ok)
						emit_mem[(SW+YW)'({SW'(in_q.row), YW'(in_q.col)})] <= val_sat;
				default: ;
			endcase
		end
		if (ctl.read_k) begin
			trans_rd_q <= trans_mem[{k_idx, j_idx}];
			emit_rd_q  <= emit_mem[{j_idx, YW'(in_q.symbol)}];
			init_rd_q  <= init_mem[j_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.read_k) prev_rd_q <= score_q[k_idx];
	end

	assign cand = log_add(prev_rd_q, trans_rd_q);
	assign fin_val = started_q ? log_add(acc_q, emit_rd_q) : log_add(init_rd_q, emit_rd_q);

	always_ff @(posedge clk) begin
		if (ctl.clr_acc) first_q <= 1'b1;
		else if (ctl.acc) begin
			first_q <= 1'b0;
			if (first_q || cand > acc_q) acc_q <= cand;
		end
		if (ctl.fin_j)
			next_q[j_idx] <= fin_val;
		if (ctl.commit)
			for (int i = 0; i < MAX_STATES; i++)
				score_q[i] <= (SW'(i) == j_idx) ? fin_val : next_q[i];
		if (ctl.best_clr) begin
			best_q     <= score_q[0];
			best_idx_q <= '0;
		end else if (ctl.best_step && score_q[k_idx] > best_q) begin
			best_q     <= score_q[k_idx];
			best_idx_q <= k_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) started_q <= 1'b0;
		else if (ctl.restart) started_q <= 1'b0;
		else if (ctl.commit) started_q <= 1'b1;
	end

	assign stat.cmd     = in_q.cmd;
	assign stat.sym_ok  = {1'b0, in_q.symbol} < nsym_eff;
	assign stat.started = started_q;
	assign best_state   = best_idx_q;
	assign best_score   = best_q;
endmodule

/* rtl/ovst_ctrl.sv */
// Controller: sequences table writes, the state-pair sweep and the best search.
module ovst_ctrl #(
	parameter int MAX_STATES = ovst_pkg::MAX_STATES_DEF,
	parameter int SW         = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               res_valid,
	input  logic               res_ready,
	input  ovst_pkg::dp_stat_t stat,
	input  logic [SW:0]        n_eff,
	output ovst_pkg::ctl_cmd_t ctl,
	output logic [SW-1:0]      k_idx,
	output logic [SW-1:0]      j_idx
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_BEST = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [SW:0] k_q, j_q;
	logic last_k, last_j;

	assign k_idx  = k_q[SW-1:0];
	assign j_idx  = j_q[SW-1:0];
	assign last_k = (k_q + 1'b1) >= n_eff || !stat.started;
	assign last_j = (j_q + 1'b1) >= n_eff;
	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);

	always_comb begin
		ctl = '0;
		ctl.load_in = in_valid && in_ready;
		unique case (state_q)
			ST_DEC: begin
				ctl.wr_table = 1'b1;
				ctl.restart  = (stat.cmd == ovst_pkg::CMD_RESTART);
				ctl.clr_acc  = 1'b1;
			end
			ST_RD:   ctl.read_k = 1'b1;
			ST_ACC:  ctl.acc = 1'b1;
			ST_FIN: begin
				ctl.fin_j   = 1'b1;
				ctl.clr_acc = 1'b1;
				ctl.commit  = last_j;
			end
			ST_BEST: begin
				ctl.best_clr  = (k_q == '0);
				ctl.best_step = (k_q != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DEC;
				ST_DEC: begin
					k_q <= '0;
					j_q <= '0;
					state_q <= (stat.cmd == ovst_pkg::CMD_OBSERVE && stat.sym_ok)
						? ST_RD : ST_IDLE;
				end
				ST_RD: state_q <= ST_ACC;
				ST_ACC: begin
					if (last_k) state_q <= ST_FIN;
					else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					k_q <= '0;
					if (last_j) state_q <= ST_BEST;
					else begin
						j_q <= j_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_BEST: begin
					if ((k_q + 1'b1) >= n_eff) state_q <= ST_OUT;
					else k_q <= k_q + 1'b1;
				end
				ST_OUT: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid) else $error("ready while result pending");
	a_commit_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> state_q == ST_BEST) else $error("commit not followed by search");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> k_q < n_eff && j_q < n_eff) else $error("index out of range");
endmodule

/* tb/ovst_tb_if.sv */
// Result record type used by the testbench scoreboard.
`timescale 1ns / 100ps
package ovst_tb_types;
	typedef struct {
		logic [3:0]  best_state;
		logic [31:0] best_score;
	} track_result_t;
endpackage

/* tb/testbench.sv */
// Testbench for the online Viterbi state tracker: random table loads, sequences and config.
`timescale 1ns / 100ps
module testbench;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	class track_scoreboard;
		longint init_t[16];
		longint trans_t[16][16];
		longint emit_t[16][64];
		longint score_v[16];
		bit started;
		int nst = 16;
		int nsy = 64;
		ovst_tb_types::track_result_t pending[$];
		int errors;
		int results_seen;

		function longint log_sum(longint a, longint b);
			longint s;
			if (a == SMIN || b == SMIN) return SMIN;
			s = a + b;
			if (s > SMAX) s = SMAX;
			if (s < SMIN) s = SMIN;
			return s;
		endfunction

		function void note_beat(ovst_pkg::in_beat_t b);
			longint v;
			longint nxt[16];
			longint m;
			longint c;
			int bst;
			ovst_tb_types::track_result_t r;
			v = longint'($signed(b.value));
			case (b.cmd)
				ovst_pkg::CMD_INIT: init_t[b.row] = v;
				ovst_pkg::CMD_TRANS: if (b.col < 16) trans_t[b.row][b.col] = v;
				ovst_pkg::CMD_EMIT: emit_t[b.row][b.col] = v;
				ovst_pkg::CMD_RESTART: started = 0;
				ovst_pkg::CMD_OBSERVE: begin
					if (b.symbol >= nsy) return;
					for (int j = 0; j < nst; j++) begin
						if (!started) nxt[j] = log_sum(init_t[j], emit_t[j][b.symbol]);
						else begin
							m = log_sum(score_v[0], trans_t[0][j]);
							for (int k = 1; k < nst; k++) begin
								c = log_sum(score_v[k], trans_t[k][j]);
								if (c > m) m = c;
							end
							nxt[j] = log_sum(m, emit_t[j][b.symbol]);
						end
					end
					for (int j = 0; j < nst; j++) score_v[j] = nxt[j];
					started = 1;
					bst = 0;
					for (int k = 1; k < nst; k++) if (score_v[k] > score_v[bst]) bst = k;
					r.best_state = bst[3:0];
					r.best_score = score_v[bst][31:0];
					pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(ovst_pkg::out_beat_t o);
			ovst_tb_types::track_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result state %0d score %0h", $time,
					o.best_state, o.best_score);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.best_state !== o.best_state) begin
				$display("%0t: best_state expected %0d actual %0d", $time,
					e.best_state, o.best_state);
				errors++;
			end
			if (e.best_score !== o.best_score) begin
				$display("%0t: best_score expected %0h actual %0h", $time,
					e.best_score, o.best_score);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ovst_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ovst_if #(.payload_t(ovst_pkg::in_beat_t)) in_ch (clk);
	ovst_if #(.payload_t(ovst_pkg::out_beat_t)) out_ch (clk);

	online_viterbi_state_tracker_top uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	track_scoreboard sb;
	int items_sent;
	int stall_mode;
	int burst_left;
	bit done_sending;

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= ($urandom_range(0, 3) != 0);
			default: out_ch.ready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	task automatic reg_write(input int idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ovst_pkg::PADDR_W'(idx * 4); pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == ovst_pkg::REG_NUM_STATES)
			sb.nst = (v[4:0] == 0) ? 1 : (v[4:0] > 16 ? 16 : v[4:0]);
		else sb.nsy = (v[6:0] == 0) ? 1 : (v[6:0] > 64 ? 64 : v[6:0]);
	endtask

	task automatic send_beat(input ovst_pkg::in_beat_t b);
		if (burst_left == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 20) : 1000;
		end
		burst_left--;
		in_ch.valid <= 1;
		in_ch.data <= b;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_beat(b);
		items_sent++;
	endtask

	task automatic settle();
		@(posedge clk);
		in_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return -$urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	function automatic ovst_pkg::in_beat_t mk(logic [2:0] c, int r, int cl, logic [31:0] v,
		int s);
		ovst_pkg::in_beat_t b;
		b.cmd = c; b.row = r[3:0]; b.col = cl[5:0]; b.value = v; b.symbol = s[5:0];
		return b;
	endfunction

	task automatic load_tables(input int n, input int m);
		for (int i = 0; i < n; i++)
			send_beat(mk(ovst_pkg::CMD_INIT, i, $urandom, rand_value(), $urandom));
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				send_beat(mk(ovst_pkg::CMD_TRANS, i, j, rand_value(), $urandom));
		for (int i = 0; i < n; i++)
			for (int s = 0; s < m; s++)
				send_beat(mk(ovst_pkg::CMD_EMIT, i, s, rand_value(), $urandom));
	endtask

	task automatic run_phase(input int n, input int m, input int count);
		int r;
		reg_write(ovst_pkg::REG_NUM_STATES, n);
		reg_write(ovst_pkg::REG_NUM_SYMBOLS, m);
		load_tables(n, m);
		send_beat(mk(ovst_pkg::CMD_RESTART, 0, 0, 0, 0));
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			if (r < 13) send_beat(mk(ovst_pkg::CMD_OBSERVE, $urandom, $urandom, $urandom,
				$urandom_range(0, m - 1)));
			else if (r == 13) send_beat(mk(ovst_pkg::CMD_RESTART, $urandom, $urandom,
				$urandom, $urandom));
			else if (r == 14) send_beat(mk(ovst_pkg::CMD_OBSERVE, 0, 0, 0, $urandom));
			else if (r == 15) send_beat(mk(3'($urandom_range(5, 7)), $urandom, $urandom,
				$urandom, $urandom));
			else if (r == 16) send_beat(mk(ovst_pkg::CMD_TRANS, $urandom_range(0, 15),
				$urandom_range(16, 63), $urandom, $urandom));
			else if (r == 17) send_beat(mk(ovst_pkg::CMD_TRANS, $urandom_range(0, n - 1),
				$urandom_range(0, n - 1), rand_value(), $urandom));
			else if (r == 18) send_beat(mk(ovst_pkg::CMD_EMIT, $urandom_range(0, n - 1),
				$urandom_range(0, m - 1), rand_value(), $urandom));
			else send_beat(mk(ovst_pkg::CMD_INIT, $urandom_range(0, n - 1), $urandom,
				rand_value(), $urandom));
		end
		settle();
	endtask

	initial begin
		sb = new();
		stall_mode = 0;
		burst_left = 1000;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		// Directed part at small sizes with extreme values and every command.
		reg_write(ovst_pkg::REG_NUM_STATES, 2);
		reg_write(ovst_pkg::REG_NUM_SYMBOLS, 2);
		send_beat(mk(ovst_pkg::CMD_INIT, 0, 0, 32'h8000_0000, 0));
		send_beat(mk(ovst_pkg::CMD_INIT, 1, 0, 32'h7fff_ffff, 0));
		send_beat(mk(ovst_pkg::CMD_TRANS, 0, 0, 32'h7fff_ffff, 0));
		send_beat(mk(ovst_pkg::CMD_TRANS, 0, 1, 32'h8000_0000, 0));
		send_beat(mk(ovst_pkg::CMD_TRANS, 1, 0, 0, 0));
		send_beat(mk(ovst_pkg::CMD_TRANS, 1, 1, 32'h7fff_ffff, 0));
		send_beat(mk(ovst_pkg::CMD_EMIT, 0, 0, 0, 0));
		send_beat(mk(ovst_pkg::CMD_EMIT, 1, 0, 32'h7fff_ffff, 0));
		send_beat(mk(ovst_pkg::CMD_EMIT, 0, 1, 32'h8000_0001, 0));
		send_beat(mk(ovst_pkg::CMD_EMIT, 1, 1, 32'h8000_0001, 0));
		send_beat(mk(ovst_pkg::CMD_EMIT, 15, 63, 0, 0));
		send_beat(mk(ovst_pkg::CMD_OBSERVE, 15, 63, 32'hffff_ffff, 0));
		send_beat(mk(ovst_pkg::CMD_OBSERVE, 0, 0, 0, 1));
		send_beat(mk(ovst_pkg::CMD_OBSERVE, 0, 0, 0, 1));
		send_beat(mk(ovst_pkg::CMD_OBSERVE, 0, 0, 0, 63));
		send_beat(mk(3'd7, 15, 63, 32'hffff_ffff, 63));
		send_beat(mk(ovst_pkg::CMD_RESTART, 0, 0, 0, 0));
		send_beat(mk(ovst_pkg::CMD_OBSERVE, 0, 0, 0, 0));
		settle();
		stall_mode = 1;
		run_phase(1, 1, 150);
		run_phase(16, 4, 60);
		stall_mode = 2;
		run_phase(4, 8, 150);
		run_phase(3, 5, 150);
		stall_mode = 1;
		run_phase(2, 64, 60);
		run_phase(5, 16, 100);
		stall_mode = 0;
		reg_write(ovst_pkg::REG_NUM_STATES, 31);
		reg_write(ovst_pkg::REG_NUM_SYMBOLS, 127);
		reg_write(ovst_pkg::REG_NUM_STATES, 0);
		reg_write(ovst_pkg::REG_NUM_SYMBOLS, 0);
		run_phase(2, 3, 100);
		settle();
		$display("Sent %0d beats over several state and symbol counts; %0d results checked.",
			items_sent, sb.results_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("online_viterbi_state_tracker_top regression: pass");
		end else begin
			$display("online_viterbi_state_tracker_top regression: fail");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("online_viterbi_state_tracker_top regression: fail");
		$finish;
	end
endmodule

/* sim.f */
rtl/ovst_pkg.sv
rtl/ovst_if.sv
rtl/ovst_dp.sv
rtl/ovst_ctrl.sv
rtl/online_viterbi_state_tracker_top.sv
tb/ovst_tb_if.sv
tb/testbench.sv
